FILE: rtl/core/facfwt_pkg.sv
package facfwt_pkg;

  // fixed field widths of the access and result transfers
  localparam int ADDR_W  = 7;
  localparam int BYTE_W  = 8;
  localparam int LINE_OW = 3;
  localparam int BLK_OW  = 5;
  localparam int CNT_W   = 32;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_value;
  } in_t;

  typedef struct packed {
    logic               hit_flag;
    logic [LINE_OW-1:0] cache_line;
    logic [BYTE_W-1:0]  data_value;
    logic [BLK_OW-1:0]  block_number;
    logic [CNT_W-1:0]   read_hits;
    logic [CNT_W-1:0]   read_misses;
    logic [CNT_W-1:0]   write_hits;
    logic [CNT_W-1:0]   write_misses;
  } out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic lookup;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/facfwt_ram.sv
module facfwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/facfwt_ctrl.sv
module facfwt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  facfwt_pkg::status_t status,
  output facfwt_pkg::cmd_t    cmd
);

  facfwt_pkg::state_t state_r;
  facfwt_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= facfwt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      facfwt_pkg::ST_CLEAR: begin
        if (status.clear_last) state_nxt = facfwt_pkg::ST_IDLE;
      end
      facfwt_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = facfwt_pkg::ST_LOOKUP;
      end
      facfwt_pkg::ST_LOOKUP: begin
        state_nxt = facfwt_pkg::ST_DONE;
      end
      facfwt_pkg::ST_DONE: begin
        if (status.out_free) state_nxt = facfwt_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = facfwt_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      facfwt_pkg::ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      facfwt_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      facfwt_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      facfwt_pkg::ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/facfwt_dp.sv
module facfwt_dp #(
  parameter int CACHE_LINES     = 8,
  parameter int MEMORY_BLOCKS   = 32,
  parameter int BYTES_PER_BLOCK = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  facfwt_pkg::in_t     in_data,
  input  facfwt_pkg::cmd_t    cmd,
  output facfwt_pkg::status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output facfwt_pkg::out_t    out_data
);

  localparam int LINE_W = $clog2(CACHE_LINES);
  localparam int BLK_W  = $clog2(MEMORY_BLOCKS);
  localparam int MEM_N  = MEMORY_BLOCKS * BYTES_PER_BLOCK;
  localparam int MEM_AW = $clog2(MEM_N);
  localparam int ADDR_N = 1 << facfwt_pkg::ADDR_W;
  localparam int CNT_W  = facfwt_pkg::CNT_W;
  localparam int BYTE_W = facfwt_pkg::BYTE_W;

  // address decode tables, built at elaboration
  logic [BLK_W-1:0]  blk_tab  [ADDR_N];
  logic [MEM_AW-1:0] maddr_tab[ADDR_N];

  for (genvar a = 0; a < ADDR_N; a++) begin : g_tab
    assign blk_tab[a]   = BLK_W'((a / BYTES_PER_BLOCK) % MEMORY_BLOCKS);
    assign maddr_tab[a] = MEM_AW'(((a / BYTES_PER_BLOCK) % MEMORY_BLOCKS) * BYTES_PER_BLOCK
                                  + (a % BYTES_PER_BLOCK));
  end

  // captured access
  logic              kind_r;
  logic [MEM_AW-1:0] maddr_r;
  logic [BLK_W-1:0]  blk_r;
  logic [BYTE_W-1:0] wval_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_data.kind;
      maddr_r <= maddr_tab[in_data.address];
      blk_r   <= blk_tab[in_data.address];
      wval_r  <= in_data.write_value;
    end
  end

  // line directory
  logic [BLK_W-1:0]       tag_r [CACHE_LINES];
  logic [CACHE_LINES-1:0] vld_r;
  logic [LINE_W-1:0]      ptr_r;
  logic [LINE_W-1:0]      ptr_nxt;
  logic [CACHE_LINES-1:0] match_vec;
  logic                   lk_hit;
  logic [LINE_W-1:0]      lk_line;

  // parallel tag compare
  for (genvar l = 0; l < CACHE_LINES; l++) begin : g_match
    assign match_vec[l] = vld_r[l] && (tag_r[l] == blk_r);
  end

  // lowest matching line wins
  always_comb begin
    lk_hit  = 1'b0;
    lk_line = '0;
    for (int l = CACHE_LINES - 1; l >= 0; l--) begin
      if (match_vec[l]) begin
        lk_hit  = 1'b1;
        lk_line = LINE_W'(l);
      end
    end
  end

  // fifo replacement pointer wraps at the last line
  assign ptr_nxt = (ptr_r == LINE_W'(CACHE_LINES - 1)) ? '0 : ptr_r + LINE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ptr_r <= '0;
    end else if (cmd.lookup && !lk_hit) begin
      vld_r[ptr_r] <= 1'b1;
      ptr_r        <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup && !lk_hit) begin
      tag_r[ptr_r] <= blk_r;
    end
  end

  // lookup result
  logic              hit_r;
  logic [LINE_W-1:0] line_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r  <= lk_hit;
      line_r <= lk_hit ? lk_line : ptr_r;
    end
  end

  // saturating hit and miss counters
  logic [CNT_W-1:0] rd_hits_r;
  logic [CNT_W-1:0] rd_miss_r;
  logic [CNT_W-1:0] wr_hits_r;
  logic [CNT_W-1:0] wr_miss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_hits_r <= '0;
      rd_miss_r <= '0;
      wr_hits_r <= '0;
      wr_miss_r <= '0;
    end else if (cmd.lookup) begin
      if (kind_r == facfwt_pkg::KIND_WRITE) begin
        if (lk_hit) begin
          if (wr_hits_r != '1) wr_hits_r <= wr_hits_r + CNT_W'(1);
        end else begin
          if (wr_miss_r != '1) wr_miss_r <= wr_miss_r + CNT_W'(1);
        end
      end else begin
        if (lk_hit) begin
          if (rd_hits_r != '1) rd_hits_r <= rd_hits_r + CNT_W'(1);
        end else begin
          if (rd_miss_r != '1) rd_miss_r <= rd_miss_r + CNT_W'(1);
        end
      end
    end
  end

  // backing store init sweep
  logic [MEM_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en && !status.clear_last) begin
      clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
    end
  end

  assign status.clear_last = (clr_cnt_r == MEM_AW'(MEM_N - 1));

  // backing store: write-through keeps every valid line equal to its block,
  // so the byte of a read hit or a fill is served from here
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [BYTE_W-1:0] mem_rdata;

  assign mem_we    = cmd.clear_en || (cmd.lookup && (kind_r == facfwt_pkg::KIND_WRITE));
  assign mem_waddr = cmd.clear_en ? clr_cnt_r : maddr_r;
  assign mem_wdata = cmd.clear_en ? BYTE_W'(clr_cnt_r) : wval_r;

  facfwt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_N)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.lookup),
    .raddr (maddr_r),
    .rdata (mem_rdata)
  );

  // output register
  logic               out_valid_r;
  facfwt_pkg::out_t   out_data_r;

  assign status.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.hit_flag     <= hit_r;
      out_data_r.cache_line   <= facfwt_pkg::LINE_OW'(line_r);
      out_data_r.data_value   <= (kind_r == facfwt_pkg::KIND_WRITE) ? wval_r : mem_rdata;
      out_data_r.block_number <= facfwt_pkg::BLK_OW'(blk_r);
      out_data_r.read_hits    <= rd_hits_r;
      out_data_r.read_misses  <= rd_miss_r;
      out_data_r.write_hits   <= wr_hits_r;
      out_data_r.write_misses <= wr_miss_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a block never sits in two valid lines
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |-> $onehot0(match_vec))
    else $error("block found in more than one valid line");

  // a miss advances the replacement pointer
  a_ptr_adv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup && !lk_hit |=> ptr_r != $past(ptr_r))
    else $error("replacement pointer did not advance on a miss");

  // the pointer moves only on a miss
  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.lookup && !lk_hit) |=> $stable(ptr_r))
    else $error("replacement pointer moved without a miss");

  // the number of valid lines does not drop after a fill
  a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup && !lk_hit |=> $countones(vld_r) >= $countones($past(vld_r)))
    else $error("valid lines dropped after a fill");

endmodule

FILE: rtl/core/fully_assoc_cache_fifo_write_through.sv
// an input transfer is captured, looked up in the tags, then loaded into the output register, raising out_valid
// the single-item control sequence takes a new access only after the last one is loaded; a stalled
// result in the output register holds the next access back until it transfers
// tag compare covers all lines in parallel; a read's byte comes from the backing store port
// reset (rst_n low, synchronous) clears valid bits, pointer and counters, then a sweep over
// all MEMORY_BLOCKS*BYTES_PER_BLOCK addresses (128 by default) loads the backing store
// with each byte equal to its address; in_stall stays high during the sweep
module fully_assoc_cache_fifo_write_through #(
  parameter int CACHE_LINES     = 8,
  parameter int MEMORY_BLOCKS   = 32,
  parameter int BYTES_PER_BLOCK = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  facfwt_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output facfwt_pkg::out_t out_data
);

  facfwt_pkg::cmd_t    cmd;
  facfwt_pkg::status_t status;

  // sequencing
  facfwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // directory, counters, backing store and output register
  facfwt_dp #(
    .CACHE_LINES     (CACHE_LINES),
    .MEMORY_BLOCKS   (MEMORY_BLOCKS),
    .BYTES_PER_BLOCK (BYTES_PER_BLOCK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
